// File: rtl/rcg_pkg.sv
// package for the river channel geometry pipeline
// holds the status codes, field limits and the exp2 root coefficients
`timescale 1ns / 1ps

package rcg_pkg;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_ZERO = 2'd1,
        ST_SAT  = 2'd2,
        ST_SEXP = 2'd3
    } t_status;

    typedef struct packed {
        logic        valid;
        logic        zf;
        logic        szf;
        logic [15:0] s;
    } t_side;

    localparam logic [23:0] Q_MAX_W = 24'hFF_FFFF;
    localparam logic [19:0] Q_MAX_D = 20'hF_FFFF;

    function automatic logic [63:0] rcg_isqrt(input logic [63:0] n);
        logic [63:0] x;
        logic [63:0] r;
        logic [63:0] b;
        x = n;
        r = '0;
        b = 64'd1 << 62;
        for (int j = 0; j < 32; j++) begin
            if (x >= r + b) begin
                x = x - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    // c_k = sqrt(2)^(1/2^(k-1)) in q1.31, built by repeated root
    function automatic logic [31:0] rcg_coef(input int k);
        logic [63:0] c;
        c = 64'd1 << 32;
        for (int j = 1; j <= 24; j++) begin
            if (j <= k) begin
                c = rcg_isqrt(c << 31);
            end
        end
        return c[31:0];
    endfunction

endpackage

// File: rtl/rcg_dly.sv
// sideband delay line, keeps valid and flags aligned with the datapath
// no dependencies
`timescale 1ns / 1ps

module rcg_dly #(
    parameter int W = 8,
    parameter int N = 4
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_en,
    input  logic [W-1:0] i_d,
    output logic [W-1:0] o_q
);

    logic [W-1:0] r_sh [0:N-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < N; k++) begin
                r_sh[k] <= '0;
            end
        end else if (i_en) begin
            r_sh[0] <= i_d;
            for (int k = 1; k < N; k++) begin
                r_sh[k] <= r_sh[k-1];
            end
        end
    end

    assign o_q = r_sh[N-1];

endmodule

// File: rtl/rcg_log2.sv
// pipelined fixed-point log2 of a 32-bit integer
// one normalise stage then one squaring stage per fraction bit
`timescale 1ns / 1ps

module rcg_log2 #(
    parameter int F = 16
) (
    input  logic         i_clk,
    input  logic         i_en,
    input  logic [31:0]  i_x,
    output logic [F+4:0] o_log
);

    logic [4:0]   n_p;
    logic [31:0]  n_m0;
    logic [31:0]  r_m   [0:F];
    logic [F+4:0] r_acc [0:F];

    always_comb begin
        n_p = '0;
        for (int b = 0; b < 32; b++) begin
            if (i_x[b]) begin
                n_p = 5'(b);
            end
        end
        n_m0 = i_x << (5'd31 - n_p);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_m[0]   <= n_m0;
            r_acc[0] <= (F+5)'(n_p);
        end
    end

    for (genvar k = 0; k < F; k++) begin : g_sq
        logic [63:0] sq;
        logic [32:0] t;
        assign sq = r_m[k] * r_m[k];
        assign t  = sq[63:31];
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_m[k+1]   <= t[32] ? t[32:1] : t[31:0];
                r_acc[k+1] <= {r_acc[k][F+3:0], t[32]};
            end
        end
    end

    assign o_log = r_acc[F];

endmodule

// File: rtl/rcg_div.sv
// pipelined signed divide of (x * 4096) by a 17-bit divisor, truncating
// one restoring quotient bit per stage, sign applied in the last stage
`timescale 1ns / 1ps

module rcg_div #(
    parameter int F = 16
) (
    input  logic                i_clk,
    input  logic                i_en,
    input  logic signed [F+13:0] i_x,
    input  logic [16:0]         i_d,
    output logic signed [F+13:0] o_q
);

    localparam int XW = F + 14;
    localparam int QB = F + 13;

    logic [XW-1:0]        n_mag;
    logic [16:0]          r_rem [0:QB];
    logic [QB-1:0]        r_low [0:QB];
    logic [16:0]          r_dv  [0:QB];
    logic                 r_neg [0:QB];
    logic signed [XW-1:0] r_q;

    assign n_mag = i_x[XW-1] ? XW'(-i_x) : XW'(i_x);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0] <= 17'(n_mag[XW-1:F+1]);
            r_low[0] <= {n_mag[F:0], 12'd0};
            r_dv[0]  <= i_d;
            r_neg[0] <= i_x[XW-1];
        end
    end

    for (genvar j = 0; j < QB; j++) begin : g_step
        logic [17:0] t;
        logic        ge;
        assign t  = {r_rem[j], r_low[j][QB-1]};
        assign ge = t >= {1'b0, r_dv[j]};
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[j+1] <= ge ? 17'(t - {1'b0, r_dv[j]}) : t[16:0];
                r_low[j+1] <= {r_low[j][QB-2:0], ge};
                r_dv[j+1]  <= r_dv[j];
                r_neg[j+1] <= r_neg[j];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_q <= r_neg[QB] ? -$signed({1'b0, r_low[QB]}) : $signed({1'b0, r_low[QB]});
        end
    end

    assign o_q = r_q;

endmodule

// File: rtl/rcg_exp2.sv
// pipelined fixed-point exp2 with saturation to an OW-bit raw result
// one coefficient multiply per fraction bit, uses rcg_pkg coefficients
`timescale 1ns / 1ps

module rcg_exp2 #(
    parameter int F  = 16,
    parameter int YW = 38,
    parameter int OW = 24
) (
    input  logic                 i_clk,
    input  logic                 i_en,
    input  logic signed [YW-1:0] i_y,
    output logic [OW-1:0]        o_res,
    output logic                 o_sat
);

    import rcg_pkg::*;

    localparam int IW = YW - F;
    localparam logic [31:0] MAXV = 32'({OW{1'b1}});

    logic signed [IW-1:0] r_i [0:F];
    logic [F-1:0]         r_f [0:F];
    logic [31:0]          r_m [0:F];
    logic [4:0]           n_sh;
    logic [31:0]          n_shifted;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_i[0] <= IW'(i_y >>> F);
            r_f[0] <= i_y[F-1:0];
            r_m[0] <= 32'h8000_0000;
        end
    end

    for (genvar k = 1; k <= F; k++) begin : g_mul
        localparam logic [31:0] C = rcg_coef(k);
        logic [63:0] prod;
        assign prod = r_m[k-1] * C;
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_m[k] <= r_f[k-1][F-k] ? prod[62:31] : r_m[k-1];
                r_i[k] <= r_i[k-1];
                r_f[k] <= r_f[k-1];
            end
        end
    end

    assign n_sh      = 5'd31 - r_i[F][4:0];
    assign n_shifted = r_m[F] >> n_sh;

    always_comb begin
        o_sat = 1'b0;
        o_res = '0;
        priority if (r_i[F] >= $signed(IW'(31))) begin
            o_sat = 1'b1;
            o_res = MAXV[OW-1:0];
        end else if (r_i[F][IW-1]) begin
            o_res = '0;
        end else if (n_shifted > MAXV) begin
            o_sat = 1'b1;
            o_res = MAXV[OW-1:0];
        end else begin
            o_res = n_shifted[OW-1:0];
        end
    end

endmodule

// File: rtl/river_channel_geometry_from_flow.sv
// top level: flow width and depth of a power-law channel, one grid cell per transaction
// uses rcg_pkg, rcg_dly, rcg_log2, rcg_div and rcg_exp2
`timescale 1ns / 1ps

// input channel: i_in_valid / o_in_ready with discharge, shape exponent, mean depth,
// mean width and mean velocity. output channel: o_out_valid / i_out_ready with flow
// width, flow depth and status.
// the path from acceptance to the result runs through the log2 squaring chain, the
// one-bit-per-stage divider and the exp2 multiply chain. throughput is one transaction
// per cycle as long as the receiver does not hold the output register.
// status: ok, zero input (outputs zero), saturated, zero exponent (outputs zero).
// the whole pipeline advances together; while a result sits in the output
// register and the receiver holds i_out_ready low, every stage holds and
// o_in_ready is low. empty stages move on as long as the output register is free.
// reset (synchronous, active low) clears all valid bits; results already in flight
// are dropped and the block is ready in the cycle after reset is released.

module river_channel_geometry_from_flow #(
    parameter int LOG_FRAC_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [31:0] i_discharge,
    input  logic [15:0] i_shape_exponent,
    input  logic [19:0] i_mean_depth,
    input  logic [23:0] i_mean_width,
    input  logic [15:0] i_mean_velocity,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [23:0] o_flow_width,
    output logic [19:0] o_flow_depth,
    output logic [1:0]  o_status
);

    import rcg_pkg::*;

    localparam int F  = LOG_FRAC_BITS;
    localparam int XW = F + 14;
    localparam int PW = XW + 17;
    localparam int YW = F + 22;
    localparam int SW = $bits(t_side);
    localparam logic signed [XW-1:0] L8X  = XW'(8 << F);
    localparam logic signed [XW-1:0] L12X = XW'(12 << F);
    localparam logic signed [YW-1:0] L8Y  = YW'(8 << F);
    localparam logic signed [YW-1:0] L12Y = YW'(12 << F);

    logic en;

    // input register
    logic        r0_valid;
    logic [31:0] r0_q;
    logic [15:0] r0_s;
    logic [19:0] r0_d;
    logic [23:0] r0_w;
    logic [15:0] r0_v;

    logic [F+4:0] w_lq, w_lv, w_lw, w_ld, w_ls, w_ls1;
    t_side        n_side0, w_side1;

    // log-domain arithmetic stages
    t_side                r_a1_side, r_a2_side, r_a3_side, r_a4_side;
    logic signed [XW-1:0] r_a1_area, r_a1_lw, r_a1_ldm, r_a1_lsd;
    logic signed [PW-1:0] r_a2_p1;
    logic signed [XW-1:0] r_a2_area, r_a2_ldm, r_a2_lsd;
    logic signed [XW-1:0] r_a3_alpha, r_a3_sum;
    logic signed [XW-1:0] r_a4_lw0;
    logic signed [YW-1:0] r_a4_alpha12;
    logic signed [PW-1:0] n_p1adj;
    logic signed [17:0]   n_si1;

    logic signed [XW-1:0] w_q;
    logic [SW+YW-1:0]     w_dly2;
    t_side                w_side2;
    logic signed [YW-1:0] w_alpha12;

    t_side                r_d1_side, r_d2_side;
    logic signed [PW-1:0] r_d1_p2;
    logic signed [YW-1:0] r_d1_alpha12, r_d1_yw;
    logic signed [YW-1:0] r_d2_yw, r_d2_yd;
    logic signed [PW-1:0] n_p2adj;
    logic signed [17:0]   n_si2;

    logic [23:0] w_ew;
    logic [19:0] w_ed;
    logic        w_satw, w_satd;
    t_side       w_side3;

    logic        r_out_valid;
    logic [23:0] r_out_w;
    logic [19:0] r_out_d;
    t_status     r_out_st;
    t_status     n_st;
    logic [23:0] n_ow;
    logic [19:0] n_od;

    assign en         = !r_out_valid || i_out_ready;
    assign o_in_ready = en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r0_valid <= 1'b0;
        end else if (en) begin
            r0_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r0_q <= i_discharge;
            r0_s <= i_shape_exponent;
            r0_d <= i_mean_depth;
            r0_w <= i_mean_width;
            r0_v <= i_mean_velocity;
        end
    end

    rcg_log2 #(.F(F)) u_log_q (.i_clk, .i_en(en), .i_x(r0_q), .o_log(w_lq));
    rcg_log2 #(.F(F)) u_log_v (.i_clk, .i_en(en), .i_x({16'd0, r0_v}), .o_log(w_lv));
    rcg_log2 #(.F(F)) u_log_w (.i_clk, .i_en(en), .i_x({8'd0, r0_w}), .o_log(w_lw));
    rcg_log2 #(.F(F)) u_log_d (.i_clk, .i_en(en), .i_x({12'd0, r0_d}), .o_log(w_ld));
    rcg_log2 #(.F(F)) u_log_s (.i_clk, .i_en(en), .i_x({16'd0, r0_s}), .o_log(w_ls));
    rcg_log2 #(.F(F)) u_log_s1 (
        .i_clk, .i_en(en), .i_x({15'd0, {1'b0, r0_s} + 17'd4096}), .o_log(w_ls1)
    );

    always_comb begin
        n_side0.valid = r0_valid;
        n_side0.zf    = (r0_q == '0) || (r0_d == '0) || (r0_w == '0) || (r0_v == '0);
        n_side0.szf   = (r0_s == '0);
        n_side0.s     = r0_s;
    end

    rcg_dly #(.W(SW), .N(F + 1)) u_dly1 (
        .i_clk, .i_rst_n, .i_en(en), .i_d(n_side0), .o_q(w_side1)
    );

    assign n_si1   = $signed({2'b00, r_a1_side.s});
    assign n_p1adj = r_a2_p1 + (r_a2_p1[PW-1] ? PW'(4095) : PW'(0));
    assign n_si2   = $signed({2'b00, w_side2.s});
    assign n_p2adj = r_d1_p2 + (r_d1_p2[PW-1] ? PW'(4095) : PW'(0));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a1_side <= '0;
            r_a2_side <= '0;
            r_a3_side <= '0;
            r_a4_side <= '0;
            r_d1_side <= '0;
            r_d2_side <= '0;
        end else if (en) begin
            r_a1_side <= w_side1;
            r_a2_side <= r_a1_side;
            r_a3_side <= r_a2_side;
            r_a4_side <= r_a3_side;
            r_d1_side <= w_side2;
            r_d2_side <= r_d1_side;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_a1_area <= $signed(XW'(w_lq)) - $signed(XW'(w_lv));
            r_a1_lw   <= $signed(XW'(w_lw)) - L8X;
            r_a1_ldm  <= $signed(XW'(w_ld)) - L12X;
            r_a1_lsd  <= $signed(XW'(w_ls1)) - $signed(XW'(w_ls));

            r_a2_p1   <= PW'(n_si1 * r_a1_lw);
            r_a2_area <= r_a1_area;
            r_a2_ldm  <= r_a1_ldm;
            r_a2_lsd  <= r_a1_lsd;

            r_a3_alpha <= r_a2_ldm - XW'(n_p1adj >>> 12);
            r_a3_sum   <= r_a2_lsd + r_a2_area;

            r_a4_lw0     <= r_a3_sum - r_a3_alpha;
            r_a4_alpha12 <= YW'(r_a3_alpha) + L12Y;

            r_d1_p2      <= PW'(n_si2 * w_q);
            r_d1_alpha12 <= w_alpha12;
            r_d1_yw      <= YW'(w_q) + L8Y;

            r_d2_yw <= r_d1_yw;
            r_d2_yd <= r_d1_alpha12 + YW'(n_p2adj >>> 12);
        end
    end

    rcg_div #(.F(F)) u_div (
        .i_clk, .i_en(en), .i_x(r_a4_lw0), .i_d({1'b0, r_a4_side.s} + 17'd4096), .o_q(w_q)
    );

    rcg_dly #(.W(SW + YW), .N(F + 15)) u_dly2 (
        .i_clk, .i_rst_n, .i_en(en), .i_d({r_a4_side, r_a4_alpha12}), .o_q(w_dly2)
    );

    assign w_side2   = w_dly2[SW+YW-1:YW];
    assign w_alpha12 = $signed(w_dly2[YW-1:0]);

    rcg_exp2 #(.F(F), .YW(YW), .OW(24)) u_exp_w (
        .i_clk, .i_en(en), .i_y(r_d2_yw), .o_res(w_ew), .o_sat(w_satw)
    );

    rcg_exp2 #(.F(F), .YW(YW), .OW(20)) u_exp_d (
        .i_clk, .i_en(en), .i_y(r_d2_yd), .o_res(w_ed), .o_sat(w_satd)
    );

    rcg_dly #(.W(SW), .N(F + 1)) u_dly3 (
        .i_clk, .i_rst_n, .i_en(en), .i_d(r_d2_side), .o_q(w_side3)
    );

    always_comb begin
        n_ow = w_ew;
        n_od = w_ed;
        priority if (w_side3.zf) begin
            n_st = ST_ZERO;
            n_ow = '0;
            n_od = '0;
        end else if (w_side3.szf) begin
            n_st = ST_SEXP;
            n_ow = '0;
            n_od = '0;
        end else if (w_satw || w_satd) begin
            n_st = ST_SAT;
        end else begin
            n_st = ST_OK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid <= w_side3.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out_w  <= n_ow;
            r_out_d  <= n_od;
            r_out_st <= n_st;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_flow_width = r_out_w;
    assign o_flow_depth = r_out_d;
    assign o_status     = r_out_st;

    a_zero_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_status == ST_ZERO || o_status == ST_SEXP)
        |-> o_flow_width == '0 && o_flow_depth == '0)
        else $error("zero status with nonzero result");

    a_sat_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status == ST_SAT
        |-> o_flow_width == Q_MAX_W || o_flow_depth == Q_MAX_D)
        else $error("saturated status without a saturated field");

    a_ready_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> o_in_ready)
        else $error("input stalled with an empty output register");

endmodule
